FILE: rtl/core/packed_command_unpacker_defines.svh
// Assertion macros used by the checker file.
`ifndef PACKED_COMMAND_UNPACKER_DEFINES_SVH
`define PACKED_COMMAND_UNPACKER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PCU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PCU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pcu_pkg.sv
package pcu_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned COUNT_W = 6;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} pcu_state_t;

	typedef struct packed {
		logic latch;
		logic take_param;
		logic emit_scan;
	} pcu_cmd_t;

	typedef struct packed {
		logic pending_zero;
		logic param_last;
		logic scan_more;
		logic scan_last;
		logic out_free;
	} pcu_status_t;

	// Parameter counts for command codes 0x00 to 0x7F.
	localparam logic [COUNT_W-1:0] PARAM_ROM [128] = '{
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd0, 6'd1, 6'd1, 6'd1, 6'd0, 6'd16, 6'd12,
		6'd16, 6'd12, 6'd9, 6'd3, 6'd3, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd1, 6'd1, 6'd2, 6'd1, 6'd1, 6'd1, 6'd1,
		6'd1, 6'd1, 6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd1, 6'd1, 6'd1, 6'd32, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd3, 6'd2, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
	};

	// Codes with the top bit set take no parameters.
	function automatic logic [COUNT_W-1:0] cmd_arg_count(input logic [CODE_W-1:0] code);
		logic [COUNT_W-1:0] cnt;
		cnt = code[CODE_W-1] ? '0 : PARAM_ROM[code[CODE_W-2:0]];
		return cnt;
	endfunction

endpackage

FILE: rtl/core/pcu_datapath.sv
module pcu_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcu_pkg::pcu_cmd_t             cmd,
	output pcu_pkg::pcu_status_t          status,
	input  logic [pcu_pkg::WORD_W-1:0]    data_word,
	output logic                          cmd_valid,
	input  logic                          cmd_stall,
	output logic [pcu_pkg::CODE_W-1:0]    command_code,
	output logic [pcu_pkg::WORD_W-1:0]    parameter_word,
	output logic                          last_of_run
);

	logic [pcu_pkg::WORD_W-1:0]  pending_q;
	logic [pcu_pkg::COUNT_W-1:0] params_q;
	logic                        out_valid_q;
	logic [pcu_pkg::CODE_W-1:0]  code_q;
	logic [pcu_pkg::WORD_W-1:0]  param_q;
	logic                        last_q;

	logic [pcu_pkg::CODE_W-1:0]  low_code;
	logic [pcu_pkg::COUNT_W-1:0] low_count;
	logic [pcu_pkg::COUNT_W-1:0] params_inc;
	logic                        param_done;
	logic [pcu_pkg::WORD_W-1:0]  shifted;
	logic [pcu_pkg::WORD_W-1:0]  after_param;
	logic                        load;

	assign low_code    = pending_q[pcu_pkg::CODE_W-1:0];
	assign low_count   = pcu_pkg::cmd_arg_count(low_code);
	assign params_inc  = params_q + 6'd1;
	assign param_done  = params_inc >= low_count;
	assign shifted     = pending_q >> pcu_pkg::CODE_W;
	assign after_param = param_done ? shifted : pending_q;
	assign load        = cmd.take_param | cmd.emit_scan;

	always_comb begin
		status.pending_zero = pending_q == '0;
		status.param_last   = !((after_param != '0) &&
			(pcu_pkg::cmd_arg_count(after_param[pcu_pkg::CODE_W-1:0]) == '0));
		status.scan_more    = (pending_q != '0) && (low_count == '0);
		status.scan_last    = !((shifted != '0) &&
			(pcu_pkg::cmd_arg_count(shifted[pcu_pkg::CODE_W-1:0]) == '0));
		status.out_free     = !out_valid_q || !cmd_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			params_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				pending_q <= data_word;
			end else if (cmd.take_param) begin
				pending_q <= after_param;
				params_q  <= param_done ? '0 : params_inc;
			end else if (cmd.emit_scan) begin
				pending_q <= shifted;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!cmd_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q  <= low_code;
			param_q <= cmd.take_param ? data_word : '0;
			last_q  <= cmd.take_param ? status.param_last : status.scan_last;
		end
	end

	assign cmd_valid      = out_valid_q;
	assign command_code   = code_q;
	assign parameter_word = param_q;
	assign last_of_run    = last_q;

endmodule

FILE: rtl/core/pcu_controller.sv
module pcu_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	output logic                 data_stall,
	input  pcu_pkg::pcu_status_t status,
	output pcu_pkg::pcu_cmd_t    cmd
);

	pcu_pkg::pcu_state_t state_q;
	pcu_pkg::pcu_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcu_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		data_stall = 1'b1;
		case (state_q)
			pcu_pkg::ST_IDLE: begin
				data_stall = !status.out_free;
				if (data_valid && status.out_free) begin
					if (status.pending_zero) begin
						cmd.latch  = 1'b1;
						state_next = pcu_pkg::ST_SCAN;
					end else begin
						cmd.take_param = 1'b1;
						if (!status.param_last) begin
							state_next = pcu_pkg::ST_SCAN;
						end
					end
				end
			end
			pcu_pkg::ST_SCAN: begin
				if (!status.scan_more) begin
					state_next = pcu_pkg::ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit_scan = 1'b1;
					if (status.scan_last) begin
						state_next = pcu_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_next = pcu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/packed_command_unpacker.sv
// Channel   Direction  Payload                                      Handshake
// data      in         data_word                                    data_valid / data_stall
// cmd       out        command_code, parameter_word, last_of_run    cmd_valid / cmd_stall
//
// A parameter word is issued with its command, and each further command it releases follows in turn.
// A packed word is latched first and then issues one command after another, or an idle step if none.
// The single output register issues at most one command word per cycle while cmd_stall is low.
// Reset clears the pending commands, the parameter count and the output valid.
// A stall on the command side holds the output word and stalls the data side.
module packed_command_unpacker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       data_valid,
	output logic                       data_stall,
	input  logic [pcu_pkg::WORD_W-1:0] data_word,
	output logic                       cmd_valid,
	input  logic                       cmd_stall,
	output logic [pcu_pkg::CODE_W-1:0] command_code,
	output logic [pcu_pkg::WORD_W-1:0] parameter_word,
	output logic                       last_of_run
);

	pcu_pkg::pcu_cmd_t    cmd;
	pcu_pkg::pcu_status_t status;

	pcu_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.status     (status),
		.cmd        (cmd)
	);

	pcu_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.data_word      (data_word),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.command_code   (command_code),
		.parameter_word (parameter_word),
		.last_of_run    (last_of_run)
	);

endmodule

FILE: rtl/core/pcu_checker.sv
`include "packed_command_unpacker_defines.svh"

module pcu_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       data_stall,
	input logic                       cmd_valid,
	input logic                       cmd_stall,
	input logic [pcu_pkg::CODE_W-1:0] command_code,
	input logic [pcu_pkg::WORD_W-1:0] parameter_word,
	input logic                       last_of_run
);

	`PCU_ASSERT_NEXT(a_out_hold, cmd_valid && cmd_stall, cmd_valid && $stable(command_code) && $stable(parameter_word) && $stable(last_of_run), "stalled command word changed")
	`PCU_ASSERT_NOW(a_run_blocks_input, cmd_valid && !last_of_run, data_stall, "data word taken while a run is still open")
	`PCU_ASSERT_NOW(a_high_code_no_param, cmd_valid && command_code[7], parameter_word == '0, "high command code issued with a parameter")
	`PCU_ASSERT_NEXT(a_run_continues, cmd_valid && !cmd_stall && !last_of_run, cmd_valid, "run broke before its last command")

endmodule

bind packed_command_unpacker pcu_checker u_pcu_checker (.*);

FILE: tb/sv/tb.sv
module tb;

	localparam int NUM_DIRECTED = 21;
	localparam int NUM_RANDOM   = 80;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic [pcu_pkg::CODE_W-1:0] code;
		logic [pcu_pkg::WORD_W-1:0] param;
		logic                       last;
	} cmd_t;

	typedef struct packed {
		logic [pcu_pkg::WORD_W-1:0] word;
		logic                       fixed;
		logic                       n;
		logic [pcu_pkg::CODE_W-1:0] code;
		logic [pcu_pkg::WORD_W-1:0] param;
	} dir_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       data_valid;
	logic                       data_stall;
	logic [pcu_pkg::WORD_W-1:0] data_word;
	logic                       cmd_valid;
	logic                       cmd_stall;
	logic [pcu_pkg::CODE_W-1:0] command_code;
	logic [pcu_pkg::WORD_W-1:0] parameter_word;
	logic                       last_of_run;

	logic [pcu_pkg::WORD_W-1:0]  pend_bytes;
	logic [pcu_pkg::COUNT_W-1:0] taken;
	cmd_t                        released_cmds[$];
	cmd_t                        owed_cmds[$];
	cmd_t                        head_cmd;
	dir_row_t                    directed_rows [NUM_DIRECTED];

	int errors;
	int cycles;
	bit hold_on;
	bit calm;

	packed_command_unpacker dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_word(data_word),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command_code(command_code),
		.parameter_word(parameter_word),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [pcu_pkg::COUNT_W-1:0] param_need(
			input logic [pcu_pkg::CODE_W-1:0] code);
		case (code)
			8'h10, 8'h12, 8'h13, 8'h14: return 6'd1;
			8'h16, 8'h18: return 6'd16;
			8'h17, 8'h19: return 6'd12;
			8'h1A: return 6'd9;
			8'h1B, 8'h1C: return 6'd3;
			8'h20, 8'h21, 8'h22, 8'h24, 8'h25, 8'h26, 8'h27: return 6'd1;
			8'h28, 8'h29, 8'h2A, 8'h2B: return 6'd1;
			8'h23: return 6'd2;
			8'h30, 8'h31, 8'h32, 8'h33: return 6'd1;
			8'h34: return 6'd32;
			8'h40, 8'h50, 8'h60, 8'h72: return 6'd1;
			8'h70: return 6'd3;
			8'h71: return 6'd2;
			default: return 6'd0;
		endcase
	endfunction

	task automatic unpack_word(input logic [pcu_pkg::WORD_W-1:0] w);
		logic [pcu_pkg::CODE_W-1:0] code;
		cmd_t c;
		released_cmds.delete();
		if (pend_bytes == '0) begin
			pend_bytes = w;
		end else begin
			code = pend_bytes[pcu_pkg::CODE_W-1:0];
			released_cmds.push_back('{code, w, 1'b0});
			taken = taken + 6'd1;
			if (taken >= param_need(code)) begin
				pend_bytes = pend_bytes >> 8;
				taken = '0;
			end
		end
		while (pend_bytes != '0 && param_need(pend_bytes[pcu_pkg::CODE_W-1:0]) == '0) begin
			released_cmds.push_back('{pend_bytes[pcu_pkg::CODE_W-1:0],
				{pcu_pkg::WORD_W{1'b0}}, 1'b0});
			pend_bytes = pend_bytes >> 8;
		end
		if (released_cmds.size() > 0) begin
			c = released_cmds.pop_back();
			c.last = 1'b1;
			released_cmds.push_back(c);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(25, 8);
	endfunction

	function automatic logic [pcu_pkg::CODE_W-1:0] pick_code();
		int r;
		logic [pcu_pkg::CODE_W-1:0] c;
		r = $urandom_range(99, 0);
		if (r < 40) begin
			do c = 8'($urandom_range(8'h72, 8'h10));
			while (param_need(c) == '0 || param_need(c) > 6'd3);
		end else if (r < 50) begin
			do c = 8'($urandom_range(8'h1C, 8'h16));
			while (param_need(c) < 6'd9 || param_need(c) > 6'd12);
		end else if (r < 53) begin
			do c = 8'($urandom_range(8'h34, 8'h16));
			while (param_need(c) < 6'd16);
		end else if (r < 80) begin
			do c = 8'($urandom_range(8'hFF, 8'h00));
			while (param_need(c) != '0);
		end else begin
			c = 8'h00;
		end
		return c;
	endfunction

	function automatic logic [pcu_pkg::WORD_W-1:0] next_random_word();
		int r;
		r = $urandom_range(99, 0);
		if (pend_bytes != '0) begin
			if (r < 5)
				return '0;
			if (r < 10)
				return '1;
			return $urandom;
		end
		if (r < 12)
			return $urandom;
		if (r < 17)
			return '0;
		return {pick_code(), pick_code(), pick_code(), pick_code()};
	endfunction

	task automatic report(input string what, input logic [pcu_pkg::WORD_W-1:0] got,
			input logic [pcu_pkg::WORD_W-1:0] want);
		$display("mismatch on %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	task automatic send_word(input logic [pcu_pkg::WORD_W-1:0] w);
		int gap;
		gap = (hold_on || calm) ? 0 : pick_gap();
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_word <= w;
		do @(posedge clk);
		while (data_stall);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("packed_command_unpacker test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (owed_cmds.size() == 0) begin
				report("unexpected command word", 32'(command_code), '0);
			end else begin
				head_cmd = owed_cmds.pop_front();
				if (command_code !== head_cmd.code)
					report("command_code", 32'(command_code), 32'(head_cmd.code));
				if (parameter_word !== head_cmd.param)
					report("parameter_word", parameter_word, head_cmd.param);
				if (last_of_run !== head_cmd.last)
					report("last_of_run", 32'(last_of_run), 32'(head_cmd.last));
			end
		end
	end

	initial begin
		int n;
		cmd_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_on) begin
				cmd_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_on = 1'b0;
				cmd_stall <= 1'b0;
			end else if (calm) begin
				cmd_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					cmd_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
				cmd_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [pcu_pkg::WORD_W-1:0] w;
		int random_sent;
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_word = '0;
		errors = 0;
		cycles = 0;
		hold_on = 1'b0;
		calm = 1'b0;
		pend_bytes = '0;
		taken = '0;
		random_sent = 0;

		directed_rows[0]  = '{32'h00000000, 1'b1, 1'b0, 8'h00, 32'h00000000};
		directed_rows[1]  = '{32'h00000080, 1'b1, 1'b1, 8'h80, 32'h00000000};
		directed_rows[2]  = '{32'hFFFFFFFF, 1'b0, 1'b0, 8'h00, 32'h00000000};
		directed_rows[3]  = '{32'h00000010, 1'b1, 1'b0, 8'h00, 32'h00000000};
		directed_rows[4]  = '{32'hFFFFFFFF, 1'b1, 1'b1, 8'h10, 32'hFFFFFFFF};
		directed_rows[5]  = '{32'h00FF0010, 1'b1, 1'b0, 8'h00, 32'h00000000};
		directed_rows[6]  = '{32'h00000000, 1'b0, 1'b0, 8'h00, 32'h00000000};
		directed_rows[7]  = '{32'h10000080, 1'b0, 1'b0, 8'h00, 32'h00000000};
		directed_rows[8]  = '{32'h12345678, 1'b1, 1'b1, 8'h10, 32'h12345678};
		directed_rows[9]  = '{32'h00000070, 1'b1, 1'b0, 8'h00, 32'h00000000};
		directed_rows[10] = '{32'hA5A5A5A5, 1'b1, 1'b1, 8'h70, 32'hA5A5A5A5};
		directed_rows[11] = '{32'h5A5A5A5A, 1'b1, 1'b1, 8'h70, 32'h5A5A5A5A};
		directed_rows[12] = '{32'h00000001, 1'b1, 1'b1, 8'h70, 32'h00000001};
		directed_rows[13] = '{32'h00001311, 1'b1, 1'b1, 8'h11, 32'h00000000};
		directed_rows[14] = '{32'h80000000, 1'b1, 1'b1, 8'h13, 32'h80000000};
		directed_rows[15] = '{32'h23237F72, 1'b1, 1'b0, 8'h00, 32'h00000000};
		directed_rows[16] = '{32'h0000FFFF, 1'b0, 1'b0, 8'h00, 32'h00000000};
		directed_rows[17] = '{32'h11111111, 1'b1, 1'b1, 8'h23, 32'h11111111};
		directed_rows[18] = '{32'h22222222, 1'b0, 1'b0, 8'h00, 32'h00000000};
		directed_rows[19] = '{32'h33333333, 1'b0, 1'b0, 8'h00, 32'h00000000};
		directed_rows[20] = '{32'h44444444, 1'b1, 1'b1, 8'h23, 32'h44444444};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_word(directed_rows[i].word);
			unpack_word(directed_rows[i].word);
			if (directed_rows[i].fixed) begin
				if (directed_rows[i].n)
					owed_cmds.push_back('{directed_rows[i].code, directed_rows[i].param, 1'b1});
			end else begin
				foreach (released_cmds[k])
					owed_cmds.push_back(released_cmds[k]);
			end
		end

		while (random_sent < NUM_RANDOM) begin
			if (random_sent == 20)
				hold_on = 1'b1;
			calm = (random_sent >= 50 && random_sent < 65);
			w = next_random_word();
			if (!(pend_bytes == '0 && w == '0))
				random_sent++;
			send_word(w);
			unpack_word(w);
			foreach (released_cmds[k])
				owed_cmds.push_back(released_cmds[k]);
		end
		data_valid <= 1'b0;
		calm = 1'b0;

		while (owed_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("packed_command_unpacker test passed");
		else
			$display("packed_command_unpacker test failed");
		$finish;
	end

endmodule
